[rtl/core/bms_pkg.sv]
// shared types and codes for the bounded min stack
package bms_pkg;

    localparam int unsigned VAL_W = 32;

    typedef logic signed [VAL_W-1:0] t_val;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_MIN  = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // shift control broadcast to every cell of the chain
    typedef struct packed {
        logic push;
        logic pop;
    } t_shift_ctl;

endpackage

[rtl/core/bounded_min_stack_unit.sv]
// bounded min stack: top level with the cell chain, count and result register
//
//  channel   direction  signals                                   carries
//  request   in         i_valid / o_ready, i_op, i_push_value     one operation
//  response  out        o_valid / i_ready, o_status,              one result
//                       o_result_value, o_fill_level
//
// one request per cycle while the output side is not stalled; the result
// appears in the output register in the cycle after acceptance. the top of
// stack always sits in cell 0; push and pop shift all cells by one level together.
// a waiting result stalls input only if the downstream side is not ready.
// reset empties the stack at once; cell contents are not cleared.
module bounded_min_stack_unit #(
    parameter int unsigned DEPTH = 64,
    localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_op,
    input  logic signed [31:0]    i_push_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [1:0]            o_status,
    output logic signed [31:0]    o_result_value,
    output logic [CNT_W-1:0]      o_fill_level
);
    import bms_pkg::*;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_val w_entry [DEPTH];
    t_val w_min   [DEPTH];

    t_shift_ctl w_ctl;

    logic             r_count;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_out_valid;
    t_status          r_status;
    t_status          n_status;
    t_val             r_result;
    t_val             n_result;
    logic [CNT_W-1:0] r_fill;
    t_val             w_top_min;
    logic             w_accept;
    logic             w_empty;
    logic             w_full;
    t_op              w_op;

    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_op     = t_op'(i_op);
    assign w_empty  = (r_cnt == '0);
    assign w_full   = (r_cnt == FULL_CNT);

    // running minimum for a new top entry
    assign w_top_min = (!w_empty && (w_min[0] < i_push_value)) ? w_min[0] : i_push_value;

    always_comb begin
        w_ctl    = '0;
        n_cnt    = r_cnt;
        n_status = ST_OK;
        n_result = '0;
        case (w_op)
            OP_PUSH: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctl.push = w_accept;
                    n_cnt      = r_cnt + 1'b1;
                end
            end
            OP_POP: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_ctl.pop = w_accept;
                    n_cnt     = r_cnt - 1'b1;
                    n_result  = w_entry[0];
                end
            end
            OP_MIN: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_result = w_min[0];
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            t_val w_up_entry;
            t_val w_up_min;
            t_val w_dn_entry;
            t_val w_dn_min;

            if (g == 0) begin : g_top
                assign w_up_entry = i_push_value;
                assign w_up_min   = w_top_min;
            end else begin : g_mid
                assign w_up_entry = w_entry[g-1];
                assign w_up_min   = w_min[g-1];
            end

            // the bottom cell refills from itself on pop, its value is then unused
            if (g == DEPTH - 1) begin : g_bot
                assign w_dn_entry = w_entry[g];
                assign w_dn_min   = w_min[g];
            end else begin : g_low
                assign w_dn_entry = w_entry[g+1];
                assign w_dn_min   = w_min[g+1];
            end

            bms_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_up_entry (w_up_entry),
                .i_up_min   (w_up_min),
                .i_dn_entry (w_dn_entry),
                .i_dn_min   (w_dn_min),
                .o_entry    (w_entry[g]),
                .o_min      (w_min[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_count     <= 1'b0;
        end else begin
            r_count <= 1'b0;
            if (w_accept) begin
                r_cnt       <= n_cnt;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_result <= n_result;
            r_fill   <= n_cnt;
        end
    end

    assign o_valid        = r_out_valid && !r_count;
    assign o_status       = r_status;
    assign o_result_value = r_result;
    assign o_fill_level   = r_fill;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("stack count above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op == OP_PUSH && !w_full) |=>
            (r_cnt == CNT_W'($past(r_cnt) + 1'b1)))
        else $error("push did not grow the stack");

    a_full_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_fill_level == FULL_CNT))
        else $error("full status with stack not full");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |->
            (o_fill_level == '0 && o_result_value == '0))
        else $error("empty status with data or entries");
`endif

endmodule

[rtl/core/bms_cell.sv]
// one stack level: stored entry and running minimum, shifts with its neighbors
module bms_cell (
    input  logic              i_clk,
    input  bms_pkg::t_shift_ctl i_ctl,
    input  bms_pkg::t_val     i_up_entry,
    input  bms_pkg::t_val     i_up_min,
    input  bms_pkg::t_val     i_dn_entry,
    input  bms_pkg::t_val     i_dn_min,
    output bms_pkg::t_val     o_entry,
    output bms_pkg::t_val     o_min
);
    import bms_pkg::*;

    t_val r_entry;
    t_val r_min;
    t_val n_entry;
    t_val n_min;

    always_comb begin
        n_entry = r_entry;
        n_min   = r_min;
        if (i_ctl.push) begin
            n_entry = i_up_entry;
            n_min   = i_up_min;
        end else if (i_ctl.pop) begin
            n_entry = i_dn_entry;
            n_min   = i_dn_min;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_min   <= n_min;
    end

    assign o_entry = r_entry;
    assign o_min   = r_min;

endmodule
